// ===== src/sgr_pkg.sv =====
package sgr_pkg;

  localparam int MAX_GROUP = 64;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = $clog2(MAX_GROUP);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int CFG_W     = 7;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  // Read issued to the buffer, with the flags of the result it produces
  typedef struct packed {
    logic valid;
    logic run_last;
    logic list_end;
  } rd_req_t;

endpackage

// ===== src/sgr_ram.sv =====
module sgr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/sgr_ctrl.sv =====
module sgr_ctrl import sgr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_value,
  input  logic              in_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              room,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [DATA_W-1:0] ram_wdata,
  output logic [ADDR_W-1:0] ram_raddr,
  output rd_req_t           req
);

  state_t            state, state_next;
  logic [CFG_W-1:0]  group_size;
  logic [ADDR_W-1:0] fill, fill_next;
  logic [ADDR_W-1:0] addr, addr_next;
  logic [CNT_W-1:0]  remain, remain_next;
  logic              down, down_next;
  logic              end_flag, end_flag_next;
  logic [CNT_W-1:0]  k_eff;
  logic [CNT_W-1:0]  n;
  logic              accept;
  logic              fin;

  assign cfg_ready = 1'b1;

  // Clamp the group size into 1..MAX_GROUP
  always_comb begin
    if (group_size == '0) begin
      k_eff = CNT_W'(1);
    end else if (CNT_W'(group_size) > CNT_W'(MAX_GROUP)) begin
      k_eff = CNT_W'(MAX_GROUP);
    end else begin
      k_eff = CNT_W'(group_size);
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign n         = {1'b0, fill} + CNT_W'(1);
  assign ram_we    = accept;
  assign ram_waddr = fill;
  assign ram_wdata = in_value;
  assign ram_raddr = addr;
  assign fin       = (remain == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      group_size <= CFG_W'(1);
      fill       <= '0;
      remain     <= '0;
    end else begin
      state  <= state_next;
      fill   <= fill_next;
      remain <= remain_next;
      if (cfg_valid && cfg_ready) begin
        group_size <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr     <= addr_next;
    down     <= down_next;
    end_flag <= end_flag_next;
  end

  always_comb begin
    state_next    = state;
    fill_next     = fill;
    addr_next     = addr;
    remain_next   = remain;
    down_next     = down;
    end_flag_next = end_flag;
    req           = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (n >= k_eff) begin
            // Group complete: read back newest first
            state_next    = ST_DRAIN;
            addr_next     = fill;
            remain_next   = n;
            down_next     = 1'b1;
            end_flag_next = in_last;
          end else if (in_last) begin
            // Short tail of the list: read back in arrival order
            state_next    = ST_DRAIN;
            addr_next     = '0;
            remain_next   = n;
            down_next     = 1'b0;
            end_flag_next = 1'b1;
          end else begin
            fill_next = n[ADDR_W-1:0];
          end
        end
      end
      ST_DRAIN: begin
        if (room) begin
          req.valid    = 1'b1;
          req.run_last = fin;
          req.list_end = fin && end_flag;
          remain_next  = remain - CNT_W'(1);
          addr_next    = down ? addr - ADDR_W'(1) : addr + ADDR_W'(1);
          if (fin) begin
            state_next = ST_IDLE;
            fill_next  = '0;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/sgr_outq.sv =====
module sgr_outq import sgr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  rd_req_t           req,
  input  logic [DATA_W-1:0] rdata,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_value,
  output logic              out_run_last,
  output logic              out_list_end
);

  rd_req_t           req_d;
  logic [DATA_W-1:0] q_val [2];
  logic [1:0]        q_rl;
  logic [1:0]        q_le;
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic [1:0]        occ;
  logic              pop;

  assign out_valid    = (count != 2'd0);
  assign out_value    = q_val[rd_ptr];
  assign out_run_last = q_rl[rd_ptr];
  assign out_list_end = q_le[rd_ptr];
  assign pop          = out_valid && out_ready;

  // Count the read in flight so the two slots never overflow
  assign occ  = count + {1'b0, req_d.valid};
  assign room = (occ - {1'b0, pop}) < 2'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_d  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      req_d <= req;
      if (req_d.valid) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, req_d.valid} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (req_d.valid) begin
      q_val[wr_ptr] <= rdata;
      q_rl[wr_ptr]  <= req_d.run_last;
      q_le[wr_ptr]  <= req_d.list_end;
    end
  end

endmodule

// ===== src/stream_group_reverser_top.sv =====
// Stream group reverser.
// Input stream s_axis: tdata carries a signed 32-bit element value, tlast
// marks the final element of a list. Output stream m_axis: tdata carries the
// reordered value, tlast marks the last result caused by one input
// transaction, tuser marks the final output element of the list.
// cfg_valid/cfg_ready/cfg_data write the group size (0 acts as 1, values
// above 64 act as 64); write it only while the block is idle.
// Elements are stored in a 64-entry buffer RAM. An element that neither
// completes a group nor ends a list is absorbed and intake stays open. An
// element that does either starts a drain of n buffered elements: while
// m_axis is not stalled, the single RAM read port supplies one element per
// cycle and results stream out at one per cycle; intake pauses until the
// drain ends. Results pass the drain state, buffer read register and queue.
// A stall on m_axis pauses the buffer reads once the queue has no room left
// and stretches the intake pause; the two-entry output queue holds the
// read already in flight, so no result is lost and results resume without
// a gap once m_axis_tready returns.
// Reset clears the fill count, restores group size 1 and empties the output
// queue; buffer contents are not cleared and need not be.
module stream_group_reverser_top import sgr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] elem_value
  input  logic              s_axis_tlast,   // list_last
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] out_value
  output logic              m_axis_tlast,   // run_last
  output logic              m_axis_tuser,   // [0] list_end
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data
);

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  logic              room;
  rd_req_t           req;

  sgr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_value  (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .room      (room),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .req       (req)
  );

  sgr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_GROUP)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (req.valid),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sgr_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .rdata        (ram_rdata),
    .room         (room),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_value    (m_axis_tdata),
    .out_run_last (m_axis_tlast),
    .out_list_end (m_axis_tuser)
  );

endmodule

// ===== src/sgr_checker.sv =====
module sgr_checker import sgr_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              s_axis_tlast,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [DATA_W-1:0] m_axis_tdata,
  input logic              m_axis_tlast,
  input logic              m_axis_tuser
);

  // End of list is always the last result of its transaction
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("list end without run last");

  // A list end always triggers a drain, so intake pauses
  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("intake open right after list end");

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output changed");

endmodule

bind stream_group_reverser_top sgr_checker u_sgr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== test/tb_stream_group_reverser_top.sv =====
module tb_stream_group_reverser_top;
  import sgr_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 150;
  localparam int END_CYCLES    = 20;
  localparam int N_DIRECTED    = 28;
  localparam int N_PHASES      = 9;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic              run_last;
    logic              list_end;
  } elem_result_t;

  typedef enum logic {
    ROW_ELEM,
    ROW_SIZE
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [DATA_W-1:0] value;
    logic              last;
    logic              typed;
    logic [DATA_W-1:0] want_value;
    logic              want_end;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;   // [31:0] elem_value
  logic              s_axis_tlast = 1'b0; // list_last
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;        // [31:0] out_value
  logic              m_axis_tlast;        // run_last
  logic              m_axis_tuser;        // [0] list_end
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data = '0;

  // Predictor state
  logic [DATA_W-1:0] held_vals [MAX_GROUP];
  int unsigned       held_count = 0;
  logic [CFG_W-1:0]  group_size_cfg = CFG_W'(1);
  elem_result_t      pending_outputs [$];

  int  mismatches = 0;
  int  cycle_count = 0;
  bit  quiet_mode = 1'b1;
  int  long_hold_asks = 0;
  int  long_holds_done = 0;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_ELEM, 32'h7FFFFFFF, 1'b0, 1'b1, 32'h7FFFFFFF, 1'b0},
    '{ROW_ELEM, 32'h80000000, 1'b1, 1'b1, 32'h80000000, 1'b1},
    '{ROW_ELEM, 32'hFFFFFFFF, 1'b0, 1'b1, 32'hFFFFFFFF, 1'b0},
    '{ROW_ELEM, 32'h00000000, 1'b1, 1'b1, 32'h00000000, 1'b1},
    // size zero acts as one
    '{ROW_SIZE, 32'd0,        1'b0, 1'b0, 32'h0,        1'b0},
    '{ROW_ELEM, 32'h12345678, 1'b0, 1'b1, 32'h12345678, 1'b0},
    '{ROW_ELEM, 32'h5A5AA5A5, 1'b1, 1'b1, 32'h5A5AA5A5, 1'b1},
    '{ROW_SIZE, 32'd3,        1'b0, 1'b0, 32'h0,        1'b0},
    '{ROW_ELEM, 32'h00000001, 1'b0, 1'b0, 32'h0,        1'b0},
    '{ROW_ELEM, 32'h00000002, 1'b0, 1'b0, 32'h0,        1'b0},
    '{ROW_ELEM, 32'h00000003, 1'b0, 1'b0, 32'h0,        1'b0},
    // list ends on a partial group
    '{ROW_ELEM, 32'h00000004, 1'b0, 1'b0, 32'h0,        1'b0},
    '{ROW_ELEM, 32'h00000005, 1'b1, 1'b0, 32'h0,        1'b0},
    // group completes on the final element
    '{ROW_ELEM, 32'h80000000, 1'b0, 1'b0, 32'h0,        1'b0},
    '{ROW_ELEM, 32'h7FFFFFFF, 1'b0, 1'b0, 32'h0,        1'b0},
    '{ROW_ELEM, 32'hFFFFFFFF, 1'b1, 1'b0, 32'h0,        1'b0},
    // saturates at the buffer depth
    '{ROW_SIZE, 32'd127,      1'b0, 1'b0, 32'h0,        1'b0},
    '{ROW_ELEM, 32'h0000000A, 1'b0, 1'b0, 32'h0,        1'b0},
    '{ROW_ELEM, 32'h0000000B, 1'b0, 1'b0, 32'h0,        1'b0},
    '{ROW_ELEM, 32'h0000000C, 1'b1, 1'b0, 32'h0,        1'b0},
    '{ROW_SIZE, 32'd5,        1'b0, 1'b0, 32'h0,        1'b0},
    '{ROW_ELEM, 32'h00000011, 1'b0, 1'b0, 32'h0,        1'b0},
    '{ROW_ELEM, 32'h00000022, 1'b0, 1'b0, 32'h0,        1'b0},
    '{ROW_ELEM, 32'h00000033, 1'b0, 1'b0, 32'h0,        1'b0},
    // shrink the group below the held count
    '{ROW_SIZE, 32'd2,        1'b0, 1'b0, 32'h0,        1'b0},
    '{ROW_ELEM, 32'h00000044, 1'b0, 1'b0, 32'h0,        1'b0},
    '{ROW_SIZE, 32'd64,       1'b0, 1'b0, 32'h0,        1'b0},
    '{ROW_ELEM, 32'h00000055, 1'b1, 1'b0, 32'h0,        1'b0}
  };

  int unsigned phase_sizes [N_PHASES] = '{2, 4, 1, 64, 0, 3, 7, 127, 0};
  int          phase_items [N_PHASES] = '{30, 35, 20, 70, 15, 30, 35, 40, 35};

  stream_group_reverser_top DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned clamp_group(input int unsigned size);
    if (size < 1) begin
      return 1;
    end
    if (size > MAX_GROUP) begin
      return MAX_GROUP;
    end
    return size;
  endfunction

  // Buffer one element; queue the group it releases, if any, when record is set
  function automatic void predict_reversal(input logic [DATA_W-1:0] v, input logic last,
                                           input bit record);
    int unsigned  k;
    int unsigned  n;
    elem_result_t r;
    k = clamp_group(group_size_cfg);
    if (held_count >= MAX_GROUP) begin
      held_count = MAX_GROUP - 1;
    end
    held_vals[held_count] = v;
    n = held_count + 1;
    if (n >= k || last) begin
      for (int unsigned i = 0; i < n; i++) begin
        r.value    = (n >= k) ? held_vals[n - 1 - i] : held_vals[i];
        r.run_last = (i + 1 == n);
        r.list_end = (i + 1 == n) && last;
        if (record) begin
          pending_outputs.push_back(r);
        end
      end
      held_count = 0;
    end else begin
      held_count = n;
    end
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h80000000;
      1:       return 32'h7FFFFFFF;
      2:       return 32'h00000000;
      3:       return 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  // Leaves tvalid high after the transaction so back-to-back items need no toggle
  task automatic send_elem(input logic [DATA_W-1:0] v, input logic last, input bit typed,
                           input logic [DATA_W-1:0] want_value, input logic want_end);
    elem_result_t r;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (typed) begin
      r.value    = want_value;
      r.run_last = 1'b1;
      r.list_end = want_end;
      pending_outputs.push_back(r);
    end
    predict_reversal(v, last, !typed);
  endtask

  // Wait for every queued result, then let the last absorbed element settle
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_group_size(input logic [CFG_W-1:0] size);
    cfg_valid <= 1'b1;
    cfg_data  <= size;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    group_size_cfg = size;
  endtask

  initial begin : stimulus
    int unsigned size;
    int unsigned eff;
    int          list_left;
    logic        last;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_SIZE) begin
        settle_block();
        write_group_size(directed_rows[r].value[CFG_W-1:0]);
      end else begin
        send_elem(directed_rows[r].value, directed_rows[r].last, directed_rows[r].typed,
                  directed_rows[r].want_value, directed_rows[r].want_end);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      size = (p == N_PHASES - 1) ? $urandom_range(1, 12) : phase_sizes[p];
      eff  = clamp_group(size);
      settle_block();
      write_group_size(size[CFG_W-1:0]);
      quiet_mode = (p == 2) || (p == N_PHASES - 1);
      if (p == 1) begin
        long_hold_asks++;
      end
      list_left = 0;
      for (int it = 0; it < phase_items[p]; it++) begin
        if (list_left == 0) begin
          list_left = $urandom_range(1, 2 * eff + 2);
        end
        // stray list ends break up some lists
        if ($urandom_range(0, 9) == 0) begin
          last = 1'($urandom_range(0, 1));
        end else begin
          last = (list_left == 1);
        end
        list_left = last ? 0 : list_left - 1;
        if (!quiet_mode && $urandom_range(0, 5) == 0) begin
          s_axis_tvalid <= 1'b0;
          repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        send_elem(pick_value(), last, 1'b0, '0, 1'b0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Result side backpressure: random stalls, plus one long hold on request
  initial begin : result_sink
    int stall_len;
    forever begin
      if (long_hold_asks != long_holds_done) begin
        stall_len = LONG_HOLD;
        long_holds_done++;
      end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
        stall_len = $urandom_range(1, 13);
      end else begin
        stall_len = 0;
      end
      if (stall_len > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    elem_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_outputs.size() == 0) begin
        $display("%0t: unexpected transaction out_value=%h run_last=%b list_end=%b",
                 $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
        mismatches++;
      end else begin
        want = pending_outputs.pop_front();
        if (m_axis_tdata !== want.value) begin
          $display("%0t: out_value expected %h actual %h", $time, want.value, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tlast !== want.run_last) begin
          $display("%0t: run_last expected %b actual %b", $time, want.run_last,
                   m_axis_tlast);
          mismatches++;
        end
        if (m_axis_tuser !== want.list_end) begin
          $display("%0t: list_end expected %b actual %b", $time, want.list_end,
                   m_axis_tuser);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, pending_outputs.size());
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
